// File: sv/pbp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pbp_pkg
// Shared types and fixed constants of the perceptron branch predictor.
// ----------------------------------------------------------------------------
package pbp_pkg;

    localparam int PC_W  = 32;
    localparam int DOT_W = 23;
    localparam int THR_W = 16;

    localparam logic [THR_W-1:0] THR_RESET = 16'd178;

    localparam logic CMD_PREDICT = 1'b0;
    localparam logic CMD_UPDATE  = 1'b1;

    // Table access controls for one cycle
    typedef struct packed {
        logic wt_rd;
        logic wt_we;
        logic bias_rd;
        logic bias_we;
        logic row_set;
    } tbl_ctl_t;

endpackage
`default_nettype wire

// File: sv/pbp_row_mod.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pbp_row_mod
// Byte-serial remainder of the branch PC by HIST_LEN through two constant
// tables, then the row base address in the weight memory.
// ----------------------------------------------------------------------------
module pbp_row_mod #(
    parameter int HIST_LEN = 85
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        go,
    input  wire logic [pbp_pkg::PC_W-1:0]    pc,
    output logic                             done,
    output logic [$clog2(HIST_LEN)-1:0]      row,
    output logic [$clog2(HIST_LEN*HIST_LEN)-1:0] base
);

    localparam int ROW_W   = $clog2(HIST_LEN);
    localparam int ADDR_W  = $clog2(HIST_LEN*HIST_LEN);
    localparam int BYTE_W  = 8;
    localparam int N_BYTES = pbp_pkg::PC_W / BYTE_W;
    localparam int CNT_W   = $clog2(N_BYTES);
    localparam logic [ROW_W:0] H_K = (ROW_W+1)'(HIST_LEN);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(N_BYTES - 1);

    logic [ROW_W-1:0]        shl_mod  [2**ROW_W];
    logic [ROW_W-1:0]        byte_mod [2**BYTE_W];

    logic                    run_reg, run_next;
    logic                    mul_reg, mul_next;
    logic                    done_reg, done_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [pbp_pkg::PC_W-1:0] pc_reg, pc_next;
    logic [ROW_W-1:0]        rem_reg, rem_next;
    logic [ADDR_W-1:0]       base_reg, base_next;
    logic [BYTE_W-1:0]       pc_byte;
    logic [ROW_W:0]          rem_sum;

    // (r << 8) mod HIST_LEN and b mod HIST_LEN, fixed at elaboration
    for (genvar g = 0; g < 2**ROW_W; g++)
    begin : g_shl
        assign shl_mod[g] = ROW_W'((g << BYTE_W) % HIST_LEN);
    end

    for (genvar g = 0; g < 2**BYTE_W; g++)
    begin : g_byte
        assign byte_mod[g] = ROW_W'(g % HIST_LEN);
    end

    always_comb
    begin
        run_next  = run_reg;
        mul_next  = 1'b0;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        pc_next   = pc_reg;
        rem_next  = rem_reg;
        base_next = base_reg;
        pc_byte   = pc_reg[pbp_pkg::PC_W-1 -: BYTE_W];
        rem_sum   = {1'b0, shl_mod[rem_reg]} + {1'b0, byte_mod[pc_byte]};
        if (go)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            pc_next  = pc;
            rem_next = '0;
        end
        else if (run_reg)
        begin
            // fold in one byte per cycle, MSB first
            rem_next = (rem_sum >= H_K) ? ROW_W'(rem_sum - H_K) : ROW_W'(rem_sum);
            pc_next  = {pc_reg[pbp_pkg::PC_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                run_next = 1'b0;
                mul_next = 1'b1;
            end
        end
        else if (mul_reg)
        begin
            base_next = ADDR_W'(rem_reg * HIST_LEN);
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            mul_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            mul_reg  <= mul_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pc_reg   <= pc_next;
        rem_reg  <= rem_next;
        base_reg <= base_next;
    end

    assign done = done_reg;
    assign row  = rem_reg;
    assign base = base_reg;

endmodule
`default_nettype wire

// File: sv/pbp_tables.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pbp_tables
// Weight and bias memories with registered reads and one valid bit per row.
// A row never trained reads as zero weights and a bias of one.
// ----------------------------------------------------------------------------
module pbp_tables #(
    parameter int HIST_LEN    = 85,
    parameter int WEIGHT_BITS = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire pbp_pkg::tbl_ctl_t                    ctl,
    input  wire logic [$clog2(HIST_LEN)-1:0]          row,
    input  wire logic [$clog2(HIST_LEN*HIST_LEN)-1:0] rd_addr,
    input  wire logic [$clog2(HIST_LEN*HIST_LEN)-1:0] wr_addr,
    input  wire logic signed [WEIGHT_BITS-1:0]        wr_data,
    output logic signed [WEIGHT_BITS-1:0]             wt_q,
    output logic signed [WEIGHT_BITS-1:0]             bias_q
);

    localparam int DEPTH = HIST_LEN * HIST_LEN;

    logic signed [WEIGHT_BITS-1:0] weight_mem [DEPTH];
    logic signed [WEIGHT_BITS-1:0] bias_mem   [HIST_LEN];
    logic signed [WEIGHT_BITS-1:0] wt_q_reg;
    logic signed [WEIGHT_BITS-1:0] bias_q_reg;
    logic [HIST_LEN-1:0]           row_valid_reg;
    logic                          q_ok_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wt_we)
        begin
            weight_mem[wr_addr] <= wr_data;
        end
        if (ctl.wt_rd)
        begin
            wt_q_reg <= weight_mem[rd_addr];
        end
        if (ctl.bias_we)
        begin
            bias_mem[row] <= wr_data;
        end
        if (ctl.bias_rd)
        begin
            bias_q_reg <= bias_mem[row];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            q_ok_reg      <= 1'b0;
        end
        else
        begin
            if (ctl.row_set)
            begin
                row_valid_reg[row] <= 1'b1;
            end
            if (ctl.wt_rd || ctl.bias_rd)
            begin
                q_ok_reg <= row_valid_reg[row];
            end
        end
    end

    assign wt_q   = q_ok_reg ? wt_q_reg : '0;
    assign bias_q = q_ok_reg ? bias_q_reg : WEIGHT_BITS'(1);

endmodule
`default_nettype wire

// File: sv/perceptron_branch_predictor.sv
`default_nettype none
// ----------------------------------------------------------------------------
// perceptron_branch_predictor
// Global-history perceptron predictor walked by one shared adder.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with command, branch_pc, outcome_taken and was_predicted_taken
//   while busy is low; the item transfers at that clock edge and busy rises.
//   A predict command returns predict_taken and dot_sum; an update returns the
//   same pre-training values, then trains the row if needed and shifts the
//   outcome into the global history.
//   done is high for exactly one cycle with the result; the receiver cannot
//   stall it, and the block never waits on the receiver.
//   Sequence: byte-serial PC mod HIST_LEN, a base multiply and a handoff,
//   then bias and weight reads through the shared adder, then done rises. A
//   training update keeps busy afterwards while the same adder rewrites the
//   row. One item at a time; the walk over the row sets the rate.
//   threshold_we writes threshold_data into the training threshold at once;
//   write it only while idle.
//   Reset clears the sequencer, sets the threshold to 178, the history to
//   oldest-taken, and marks every row untrained (zero weights, bias one).
// ----------------------------------------------------------------------------
module perceptron_branch_predictor #(
    parameter int HIST_LEN    = 85,
    parameter int WEIGHT_BITS = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic                              command,
    input  wire logic [pbp_pkg::PC_W-1:0]          branch_pc,
    input  wire logic                              outcome_taken,
    input  wire logic                              was_predicted_taken,
    output logic                                   done,
    output logic                                   predict_taken,
    output logic signed [pbp_pkg::DOT_W-1:0]       dot_sum,
    input  wire logic                              threshold_we,
    input  wire logic [pbp_pkg::THR_W-1:0]         threshold_data
);

    localparam int ROW_W  = $clog2(HIST_LEN);
    localparam int IDX_W  = $clog2(HIST_LEN);
    localparam int ADDR_W = $clog2(HIST_LEN*HIST_LEN);
    localparam int ACC_W  = WEIGHT_BITS + $clog2(HIST_LEN+1) + 1;
    localparam int CMP_W  = (ACC_W > pbp_pkg::THR_W) ? ACC_W : pbp_pkg::THR_W;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(HIST_LEN - 1);
    localparam logic signed [ACC_W-1:0] ONE_EXT = ACC_W'(1);
    localparam logic signed [ACC_W-1:0] NEG_ONE = '1;
    localparam logic signed [WEIGHT_BITS-1:0] W_MAX = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
    localparam logic signed [WEIGHT_BITS-1:0] W_MIN = {1'b1, {(WEIGHT_BITS-1){1'b0}}};

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MOD   = 3'd1;
    localparam logic [2:0] S_BIAS  = 3'd2;
    localparam logic [2:0] S_WALK  = 3'd3;
    localparam logic [2:0] S_JUDGE = 3'd4;

    logic [2:0]                 state_reg, state_next;
    logic                       cmd_reg, cmd_next;
    logic                       taken_reg, taken_next;
    logic                       pred_reg, pred_next;
    logic                       pass_reg, pass_next;
    logic                       issue_done_reg, issue_done_next;
    logic [IDX_W-1:0]           widx_reg, widx_next;
    logic [ADDR_W-1:0]          addr_reg, addr_next;
    logic                       pend_reg, pend_next;
    logic                       pend_bias_reg, pend_bias_next;
    logic [IDX_W-1:0]           pend_idx_reg, pend_idx_next;
    logic [ADDR_W-1:0]          pend_addr_reg, pend_addr_next;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic [HIST_LEN-1:0]        history_reg, history_next;
    logic [pbp_pkg::THR_W-1:0]  thr_reg, thr_next;
    logic                       done_reg, done_next;
    logic                       predict_reg, predict_next;
    logic signed [pbp_pkg::DOT_W-1:0] dot_reg, dot_next;

    logic                       accept;
    logic                       mod_done;
    logic [ROW_W-1:0]           row;
    logic [ADDR_W-1:0]          base;
    pbp_pkg::tbl_ctl_t          ctl;
    logic signed [WEIGHT_BITS-1:0] wt_q;
    logic signed [WEIGHT_BITS-1:0] bias_q;
    logic signed [WEIGHT_BITS-1:0] cur;
    logic signed [WEIGHT_BITS-1:0] wr_val;
    logic signed [ACC_W-1:0]    cur_ext;
    logic signed [ACC_W-1:0]    opa;
    logic signed [ACC_W-1:0]    opb;
    logic signed [ACC_W-1:0]    add_out;
    logic                       hist_bit;
    logic                       dir;
    logic                       skip;
    logic                       last;
    logic [ACC_W-1:0]           mag;
    logic                       train;

    assign accept = start && (state_reg == S_IDLE);

    pbp_row_mod #(
        .HIST_LEN (HIST_LEN)
    ) u_row_mod (
        .clk  (clk),
        .rst_n(rst_n),
        .go   (accept),
        .pc   (branch_pc),
        .done (mod_done),
        .row  (row),
        .base (base)
    );

    pbp_tables #(
        .HIST_LEN   (HIST_LEN),
        .WEIGHT_BITS(WEIGHT_BITS)
    ) u_tables (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .row    (row),
        .rd_addr(addr_reg),
        .wr_addr(pend_addr_reg),
        .wr_data(wr_val),
        .wt_q   (wt_q),
        .bias_q (bias_q)
    );

    // Shared adder: accumulate the dot product, or step one entry by +/-1
    assign cur      = pend_bias_reg ? bias_q : wt_q;
    assign cur_ext  = ACC_W'(cur);
    assign hist_bit = history_reg[pend_idx_reg];
    assign dir      = pend_bias_reg ? taken_reg : (hist_bit == taken_reg);
    assign opa      = pass_reg ? cur_ext : acc_reg;
    assign opb      = pass_reg ? (dir ? ONE_EXT : NEG_ONE)
                               : ((pend_bias_reg || hist_bit) ? cur_ext : -cur_ext);
    assign add_out  = opa + opb;
    assign skip     = (dir && (cur == W_MAX)) || (!dir && (cur == W_MIN));
    assign wr_val   = skip ? cur : WEIGHT_BITS'(add_out);
    assign last     = pend_reg && !pend_bias_reg && (pend_idx_reg == IDX_LAST);

    assign mag   = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
    assign train = (CMP_W'(mag) <= CMP_W'(thr_reg)) || (taken_reg != pred_reg);

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        taken_next      = taken_reg;
        pred_next       = pred_reg;
        pass_next       = pass_reg;
        issue_done_next = issue_done_reg;
        widx_next       = widx_reg;
        addr_next       = addr_reg;
        pend_next       = 1'b0;
        pend_bias_next  = 1'b0;
        pend_idx_next   = pend_idx_reg;
        pend_addr_next  = pend_addr_reg;
        acc_next        = acc_reg;
        history_next    = history_reg;
        thr_next        = threshold_we ? threshold_data : thr_reg;
        done_next       = 1'b0;
        predict_next    = predict_reg;
        dot_next        = dot_reg;
        ctl             = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = command;
                    taken_next = outcome_taken;
                    pred_next  = was_predicted_taken;
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                if (mod_done)
                begin
                    pass_next  = 1'b0;
                    state_next = S_BIAS;
                end
            end
            S_BIAS:
            begin
                ctl.bias_rd     = 1'b1;
                pend_next       = 1'b1;
                pend_bias_next  = 1'b1;
                widx_next       = '0;
                addr_next       = base;
                issue_done_next = 1'b0;
                if (!pass_reg)
                begin
                    acc_next = '0;
                end
                state_next = S_WALK;
            end
            S_WALK:
            begin
                // issue the next weight read while the previous one returns
                if (!issue_done_reg)
                begin
                    ctl.wt_rd      = 1'b1;
                    pend_next      = 1'b1;
                    pend_idx_next  = widx_reg;
                    pend_addr_next = addr_reg;
                    addr_next      = addr_reg + 1'b1;
                    widx_next      = widx_reg + 1'b1;
                    if (widx_reg == IDX_LAST)
                    begin
                        issue_done_next = 1'b1;
                    end
                end
                if (pend_reg)
                begin
                    if (!pass_reg)
                    begin
                        acc_next = add_out;
                    end
                    else if (pend_bias_reg)
                    begin
                        ctl.bias_we = 1'b1;
                    end
                    else
                    begin
                        ctl.wt_we = 1'b1;
                    end
                end
                if (last)
                begin
                    if (pass_reg)
                    begin
                        ctl.row_set  = 1'b1;
                        history_next = {taken_reg, history_reg[HIST_LEN-1:1]};
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_JUDGE;
                    end
                end
            end
            S_JUDGE:
            begin
                done_next    = 1'b1;
                predict_next = !acc_reg[ACC_W-1];
                dot_next     = pbp_pkg::DOT_W'(acc_reg);
                if (cmd_reg == pbp_pkg::CMD_UPDATE)
                begin
                    if (train)
                    begin
                        pass_next  = 1'b1;
                        state_next = S_BIAS;
                    end
                    else
                    begin
                        history_next = {taken_reg, history_reg[HIST_LEN-1:1]};
                        state_next   = S_IDLE;
                    end
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pass_reg       <= 1'b0;
            issue_done_reg <= 1'b1;
            pend_reg       <= 1'b0;
            pend_bias_reg  <= 1'b0;
            history_reg    <= HIST_LEN'(1);
            thr_reg        <= pbp_pkg::THR_RESET;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pass_reg       <= pass_next;
            issue_done_reg <= issue_done_next;
            pend_reg       <= pend_next;
            pend_bias_reg  <= pend_bias_next;
            history_reg    <= history_next;
            thr_reg        <= thr_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        taken_reg     <= taken_next;
        pred_reg      <= pred_next;
        widx_reg      <= widx_next;
        addr_reg      <= addr_next;
        pend_idx_reg  <= pend_idx_next;
        pend_addr_reg <= pend_addr_next;
        acc_reg       <= acc_next;
        predict_reg   <= predict_next;
        dot_reg       <= dot_next;
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign predict_taken = predict_reg;
    assign dot_sum       = dot_reg;

endmodule
`default_nettype wire
